// ===== sv/pgrepl_pkg.sv =====
// ============================================================================
// pgrepl_pkg
// Shared types and constants for the page replacement frame table.
// ============================================================================
`default_nettype none

package pgrepl_pkg;

  // Default sizing of the frame table.
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed port widths.
  localparam int PAGE_W     = 16;
  localparam int SLOT_W     = 3;
  localparam int FAULT_W    = 32;
  localparam int FIU_W      = 4;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(8);

  typedef enum logic {
    OP_REF   = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY = 1'b0,
    REG_FRAMES = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    POL_FIFO = 1'b0,
    POL_LRU  = 1'b1
  } policy_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_t;

  // Search flags rippling from one cell to the next.
  typedef struct packed {
    logic hit_seen;
    logic empty_seen;
  } link_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic clear;
    logic touch;
    logic write;
    logic fill;
  } cell_cmd_t;

  // Per-cell search results.
  typedef struct packed {
    logic match_first;
    logic empty_first;
    logic lru_lead;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== sv/pgrepl_cell.sv =====
// ============================================================================
// pgrepl_cell
// One frame of the table: page, valid flag and recency rank.
// ============================================================================
`default_nettype none

module pgrepl_cell
  import pgrepl_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  localparam int RW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 active,
  input  wire logic                 sel,
  input  wire cell_cmd_t            cmd,
  input  wire logic [RW-1:0]        old_rank,
  input  wire logic [PAGE_BITS-1:0] key,
  input  wire logic [RW-1:0]        best_final,
  input  wire link_t                link_in,
  output link_t                     link_out,
  input  wire logic [RW-1:0]        best_in,
  output logic [RW-1:0]             best_out,
  output cell_stat_t                stat,
  output logic [PAGE_BITS-1:0]      pick_page,
  output logic [RW-1:0]             pick_rank
);

  localparam logic [RW-1:0] RANK_SAT = RW'(FRAMES - 1);

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 valid_r, valid_nxt;
  logic [RW-1:0]        rank_r, rank_nxt;
  logic                 hit_here, empty_here, lead;

  // Search: match, first empty frame, and running oldest rank.
  always_comb begin
    hit_here             = active && valid_r && (page_r == key);
    empty_here           = active && !valid_r;
    lead                 = active && (rank_r > best_in);
    link_out.hit_seen    = link_in.hit_seen | hit_here;
    link_out.empty_seen  = link_in.empty_seen | empty_here;
    best_out             = lead ? rank_r : best_in;
    stat.match_first     = hit_here && !link_in.hit_seen;
    stat.empty_first     = empty_here && !link_in.empty_seen;
    stat.lru_lead        = lead && (rank_r == best_final);
    pick_page            = sel ? page_r : '0;
    pick_rank            = sel ? rank_r : '0;
  end

  // Update: a clear empties the frame; else a touched or filled frame becomes most recent, younger ones age.
  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (cmd.clear) begin
      page_nxt  = '0;
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (sel) begin
      if (cmd.write) begin
        page_nxt = key;
      end
      if (cmd.fill) begin
        valid_nxt = 1'b1;
      end
      if (cmd.touch || cmd.fill) begin
        rank_nxt = '0;
      end
    end else if ((cmd.touch || cmd.fill) && active && valid_r &&
                 (rank_r != RANK_SAT) && (cmd.fill || (rank_r < old_rank))) begin
      rank_nxt = rank_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/page_replacement_fifo_lru_unit.sv =====
// ============================================================================
// page_replacement_fifo_lru_unit
// Fully associative page frame table with FIFO or LRU replacement.
// ============================================================================
// Usage:
//   Input channel (in_*): each transaction carries an opcode and a page
//   number. A reference looks the page up among the active frames; a clear
//   empties the table and zeroes the fault count. Every input transaction
//   yields exactly one result transaction on the out_* channel.
//   Configuration (cfg_*): index 0 selects the policy (0 FIFO, 1 LRU),
//   index 1 sets the number of active frames. cfg_ready is always high;
//   write only while the block is idle.
//   Sequencing: an item accepted at the input is evaluated in the following
//   cycle, where the row of frame cells is searched and updated, and its
//   result is then captured in the output register once that register is
//   free. The unit takes no new item while one is in evaluation; the single
//   evaluate step, with its search rippling along the cell row, sets the rate.
//   The next item is accepted while a result is still held in the output
//   register. If the receiver stalls, the result stays put and the pending
//   item waits in evaluation, so in_stall stays high until room is made.
//   Reset empties every frame, zeroes ranks, pointer and fault count, and
//   restores the FIFO policy with eight active frames.
// ============================================================================
`default_nettype none

module page_replacement_fifo_lru_unit
  import pgrepl_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input transactions
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [PAGE_W-1:0]     in_page_number,
  // Result transactions
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_hit,
  output logic [SLOT_W-1:0]          out_slot,
  output logic                       out_evicted_valid,
  output logic [PAGE_W-1:0]          out_evicted_page,
  output logic [FAULT_W-1:0]         out_fault_total,
  // Configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RW = IW;
  localparam int AW = $clog2(FRAMES + 1);

  // Control and configuration state.
  state_t               state_r, state_nxt;
  policy_t              policy_r;
  logic [FIU_W-1:0]     fiu_r;
  opcode_t              op_r;
  logic [PAGE_BITS-1:0] key_r;
  logic [IW-1:0]        ptr_r, ptr_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_ev_r;
  logic [PAGE_W-1:0]    out_evp_r;
  logic [FAULT_W-1:0]   out_fault_r;

  logic                 accept, commit, out_free;
  logic [AW-1:0]        act;
  logic [FRAMES-1:0]    active, sel;
  link_t                lnk  [FRAMES+1];
  logic [RW-1:0]        best [FRAMES+1];
  cell_stat_t           stat [FRAMES];
  logic [PAGE_BITS-1:0] pick_page [FRAMES];
  logic [RW-1:0]        pick_rank [FRAMES];
  cell_cmd_t            cmd;
  logic                 hit, any_empty, fifo_evict;
  logic [RW-1:0]        best_final, sel_rank;
  logic [PAGE_BITS-1:0] sel_page;
  logic [IW-1:0]        sel_idx, ptr_eff;
  logic [AW-1:0]        ptr_inc;
  logic [FAULT_W-1:0]   fault_sat;

  // Active frame count, clamped to 1..FRAMES.
  always_comb begin
    if (fiu_r == '0) begin
      act = AW'(1);
    end else if (int'(fiu_r) > FRAMES) begin
      act = AW'(FRAMES);
    end else begin
      act = AW'(fiu_r);
    end
  end

  // Row of frame cells; the search flags and the oldest rank so far pass
  // from each cell to its higher neighbour.
  assign lnk[0]  = '0;
  assign best[0] = '0;

  for (genvar j = 0; j < FRAMES; j++) begin : g_cell
    assign active[j] = AW'(j) < act;

    pgrepl_cell #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .active     (active[j]),
      .sel        (sel[j]),
      .cmd        (cmd),
      .old_rank   (sel_rank),
      .key        (key_r),
      .best_final (best_final),
      .link_in    (lnk[j]),
      .link_out   (lnk[j+1]),
      .best_in    (best[j]),
      .best_out   (best[j+1]),
      .stat       (stat[j]),
      .pick_page  (pick_page[j]),
      .pick_rank  (pick_rank[j])
    );

    // Frame selection: the hit, else the lowest empty frame, else the
    // victim of the current policy. With all ranks equal, LRU takes frame 0.
    assign sel[j] = hit       ? stat[j].match_first :
                    any_empty ? stat[j].empty_first :
                    (policy_r == POL_LRU) ?
                      (stat[j].lru_lead || ((j == 0) && (best_final == '0))) :
                      (ptr_eff == IW'(j));
  end

  assign hit        = lnk[FRAMES].hit_seen;
  assign any_empty  = lnk[FRAMES].empty_seen;
  assign best_final = best[FRAMES];

  // A FIFO pointer left beyond the active count wraps to frame 0.
  assign ptr_eff = (AW'(ptr_r) >= act) ? '0 : ptr_r;
  assign ptr_inc = AW'(ptr_eff) + 1'b1;

  // The selection is one-hot, so the chosen frame's data is an OR of all.
  always_comb begin
    sel_page = '0;
    sel_rank = '0;
    sel_idx  = '0;
    for (int j = 0; j < FRAMES; j++) begin
      sel_page = sel_page | pick_page[j];
      sel_rank = sel_rank | pick_rank[j];
      sel_idx  = sel_idx | (sel[j] ? IW'(j) : '0);
    end
  end

  assign fault_sat  = (&fault_r) ? fault_r : fault_r + 1'b1;
  assign fifo_evict = !hit && !any_empty && (policy_r == POL_FIFO);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    in_stall = 1'b1;
    commit   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_EVAL: begin
        commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    accept = in_valid && !in_stall;
  end

  // Cell command and the updates of pointer, fault count and result.
  always_comb begin
    cmd           = '0;
    ptr_nxt       = ptr_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (commit) begin
      out_valid_nxt = 1'b1;
      if (op_r == OP_CLEAR) begin
        cmd.clear = 1'b1;
        ptr_nxt   = '0;
        fault_nxt = '0;
      end else if (hit) begin
        cmd.touch = (policy_r == POL_LRU);
      end else begin
        fault_nxt = fault_sat;
        cmd.write = 1'b1;
        if (any_empty) begin
          cmd.fill = 1'b1;
        end else begin
          cmd.touch = 1'b1;
          if (fifo_evict) begin
            ptr_nxt = (ptr_inc >= act) ? '0 : IW'(ptr_inc);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FIFO;
      fiu_r       <= FIU_RESET;
      ptr_r       <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_POLICY: policy_r <= policy_t'(cfg_data[0]);
          REG_FRAMES: fiu_r    <= cfg_data;
          default:    fiu_r    <= fiu_r;
        endcase
      end
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode_t'(in_opcode);
      key_r <= PAGE_BITS'(in_page_number);
    end
    if (commit) begin
      if (op_r == OP_CLEAR) begin
        out_hit_r   <= 1'b0;
        out_slot_r  <= '0;
        out_ev_r    <= 1'b0;
        out_evp_r   <= '0;
        out_fault_r <= '0;
      end else begin
        out_hit_r   <= hit;
        out_slot_r  <= SLOT_W'(sel_idx);
        out_ev_r    <= !hit && !any_empty;
        out_evp_r   <= (!hit && !any_empty) ? PAGE_W'(sel_page) : '0;
        out_fault_r <= fault_nxt;
      end
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_evp_r;
  assign out_fault_total   = out_fault_r;

endmodule

`default_nettype wire

// ===== sv/pgrepl_checker.sv =====
// ============================================================================
// pgrepl_checker
// Port-level checks on the page replacement unit, bound to the top level.
// ============================================================================
`default_nettype none

module pgrepl_checker
  import pgrepl_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_hit,
  input wire logic [SLOT_W-1:0]  out_slot,
  input wire logic               out_evicted_valid,
  input wire logic [PAGE_W-1:0]  out_evicted_page,
  input wire logic [FAULT_W-1:0] out_fault_total
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_slot) &&
      $stable(out_evicted_valid) && $stable(out_evicted_page) &&
      $stable(out_fault_total))
    else $error("stalled result changed");

  // Items are taken one at a time: the cycle after an accept is stalled.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted in back-to-back cycles");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> !out_hit)
    else $error("eviction reported on a hit");

  // With no eviction, the evicted page reads zero.
  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page not zero without eviction");

  // A resident page needs at least one fault since the last clear.
  a_hit_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_fault_total != '0)
    else $error("hit reported with zero faults");

endmodule

bind page_replacement_fifo_lru_unit pgrepl_checker u_pgrepl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit           (out_hit),
  .out_slot          (out_slot),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_total   (out_fault_total)
);

`default_nettype wire
